// ===== sv/mrc_pkg.sv =====
// Shared types, constants and CRC helper for the Modbus RTU response checker.
package mrc_pkg;

  localparam int unsigned MAX_PAYLOAD_DEFAULT = 252;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SLAVE_ADDRESS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_CODE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_LENGTH = 2'd2;

  localparam logic [7:0] SLAVE_ADDRESS_RESET   = 8'd1;
  localparam logic [6:0] FUNCTION_CODE_RESET   = 7'd3;
  localparam logic [7:0] RESPONSE_LENGTH_RESET = 8'd4;

  // Frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ADDRESS   = 3'd1;
  localparam logic [2:0] ST_FORMAT    = 3'd2;
  localparam logic [2:0] ST_ILL_FUNC  = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd4;
  localparam logic [2:0] ST_BAD_DATA  = 3'd5;
  localparam logic [2:0] ST_SLAVE_FLT = 3'd6;
  localparam logic [2:0] ST_CRC       = 3'd7;

  // Exception codes carried in an exception response
  localparam logic [7:0] EXC_ILL_FUNC  = 8'h01;
  localparam logic [7:0] EXC_BAD_ADDR  = 8'h02;
  localparam logic [7:0] EXC_BAD_DATA  = 8'h03;
  localparam logic [7:0] EXC_SLAVE_FLT = 8'h04;

  // Configuration as seen by the checker core
  typedef struct packed {
    logic [7:0]  slave_address;
    logic [6:0]  function_code;
    logic [7:0]  response_length;
    logic [15:0] crc_address;     // CRC state after seed and slave address
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [2:0] frame_status;
    logic       spurious_skipped;
    logic       last_of_frame;
  } result_t;

  // Fold one byte into a reflected CRC-16, one bit per step
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] z;
    z = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (z[0]) begin
        z = (z >> 1) ^ CRC_POLY;
      end else begin
        z = z >> 1;
      end
    end
    return z;
  endfunction

endpackage

// ===== sv/mrc_cfg.sv =====
// Configuration registers with the precomputed address CRC.
module mrc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [7:0]                       cfg_data,
  output mrc_pkg::cfg_t                    cfg
);

  mrc_pkg::cfg_t cfg_reg;

  // Write registers; refresh the address CRC with the address
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.slave_address   <= mrc_pkg::SLAVE_ADDRESS_RESET;
      cfg_reg.function_code   <= mrc_pkg::FUNCTION_CODE_RESET;
      cfg_reg.response_length <= mrc_pkg::RESPONSE_LENGTH_RESET;
      cfg_reg.crc_address     <= mrc_pkg::crc_byte(mrc_pkg::CRC_SEED,
                                                   mrc_pkg::SLAVE_ADDRESS_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        mrc_pkg::REG_SLAVE_ADDRESS: begin
          cfg_reg.slave_address <= cfg_data;
          cfg_reg.crc_address   <= mrc_pkg::crc_byte(mrc_pkg::CRC_SEED, cfg_data);
        end
        mrc_pkg::REG_FUNCTION_CODE: begin
          cfg_reg.function_code <= cfg_data[6:0];
        end
        mrc_pkg::REG_RESPONSE_LENGTH: begin
          cfg_reg.response_length <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_reg;

endmodule

// ===== sv/mrc_core.sv =====
// Frame state machine: consumes one byte per step and forms the result beat.
module mrc_core #(
  parameter int unsigned MAX_PAYLOAD = mrc_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  mrc_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  output logic             emit,
  output mrc_pkg::result_t result
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SECOND  = 4'd1;
  localparam logic [3:0] PH_FUNC    = 4'd2;
  localparam logic [3:0] PH_PAYLOAD = 4'd3;
  localparam logic [3:0] PH_EXC     = 4'd4;
  localparam logic [3:0] PH_CRCLO   = 4'd5;
  localparam logic [3:0] PH_CRCHI   = 4'd6;

  localparam logic [7:0] EXC_BYTES = 8'd3;
  localparam logic [7:0] MAX_LEN   = 8'(MAX_PAYLOAD);

  logic [3:0]  phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  remaining, remaining_next;
  logic [7:0]  first_byte, first_byte_next;
  logic        spurious, spurious_next;
  logic [7:0]  exc_code, exc_code_next;
  logic [7:0]  crc_low, crc_low_next;

  logic [15:0] crc_base;
  logic [15:0] crc_fed;
  logic [7:0]  len_sat;
  logic [7:0]  remaining_dec;
  logic [7:0]  exc_now;
  logic        take_func;
  logic        status_emit;
  logic [2:0]  status;
  logic        data_emit;

  // Second-byte phase starts from the CRC of the configured address
  assign crc_base      = (phase == PH_SECOND) ? cfg.crc_address : crc;
  assign crc_fed       = mrc_pkg::crc_byte(crc_base, rx_byte);
  assign len_sat       = (cfg.response_length > MAX_LEN) ? MAX_LEN : cfg.response_length;
  assign remaining_dec = (remaining != 8'd0) ? remaining - 8'd1 : 8'd0;
  assign exc_now       = (remaining == EXC_BYTES) ? rx_byte : exc_code;

  // Compute next state and result for the current byte
  always_comb begin
    phase_next      = phase;
    crc_next        = crc;
    remaining_next  = remaining;
    first_byte_next = first_byte;
    spurious_next   = spurious;
    exc_code_next   = exc_code;
    crc_low_next    = crc_low;
    take_func       = 1'b0;
    status_emit     = 1'b0;
    status          = mrc_pkg::ST_OK;
    data_emit       = 1'b0;

    if (frame_start) begin
      crc_next        = mrc_pkg::CRC_SEED;
      spurious_next   = 1'b0;
      remaining_next  = 8'd0;
      exc_code_next   = 8'd0;
      crc_low_next    = 8'd0;
      first_byte_next = rx_byte;
      phase_next      = PH_SECOND;
    end else begin
      case (phase)
        PH_SECOND: begin
          if (first_byte == cfg.slave_address) begin
            take_func = 1'b1;
          end else if (rx_byte == cfg.slave_address) begin
            spurious_next = 1'b1;
            crc_next      = cfg.crc_address;
            phase_next    = PH_FUNC;
          end else if (rx_byte[6:0] == cfg.function_code) begin
            spurious_next = 1'b1;
            take_func     = 1'b1;
          end else begin
            status_emit = 1'b1;
            status      = mrc_pkg::ST_ADDRESS;
          end
        end
        PH_FUNC: begin
          take_func = 1'b1;
        end
        PH_PAYLOAD: begin
          crc_next       = crc_fed;
          remaining_next = remaining_dec;
          data_emit      = 1'b1;
          if (remaining_dec == 8'd0) begin
            phase_next = PH_CRCLO;
          end
        end
        PH_EXC: begin
          exc_code_next  = exc_now;
          remaining_next = remaining_dec;
          if (remaining_dec == 8'd0) begin
            status_emit = 1'b1;
            case (exc_now)
              mrc_pkg::EXC_ILL_FUNC:  status = mrc_pkg::ST_ILL_FUNC;
              mrc_pkg::EXC_BAD_ADDR:  status = mrc_pkg::ST_BAD_ADDR;
              mrc_pkg::EXC_BAD_DATA:  status = mrc_pkg::ST_BAD_DATA;
              mrc_pkg::EXC_SLAVE_FLT: status = mrc_pkg::ST_SLAVE_FLT;
              default:                status = mrc_pkg::ST_FORMAT;
            endcase
          end
        end
        PH_CRCLO: begin
          crc_low_next = rx_byte;
          phase_next   = PH_CRCHI;
        end
        PH_CRCHI: begin
          status_emit = 1'b1;
          status      = ({rx_byte, crc_low} == crc) ? mrc_pkg::ST_OK : mrc_pkg::ST_CRC;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      // Check the function byte, normal or exception form
      if (take_func) begin
        crc_next = crc_fed;
        if (rx_byte[6:0] != cfg.function_code) begin
          status_emit = 1'b1;
          status      = mrc_pkg::ST_FORMAT;
        end else if (rx_byte[7]) begin
          phase_next     = PH_EXC;
          remaining_next = EXC_BYTES;
        end else begin
          remaining_next = len_sat;
          phase_next     = (len_sat == 8'd0) ? PH_CRCLO : PH_PAYLOAD;
        end
      end

      if (status_emit) begin
        phase_next = PH_IDLE;
      end
    end
  end

  // Hold frame state; advance only on a consumed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      crc        <= mrc_pkg::CRC_SEED;
      remaining  <= 8'd0;
      first_byte <= 8'd0;
      spurious   <= 1'b0;
      exc_code   <= 8'd0;
      crc_low    <= 8'd0;
    end else if (step) begin
      phase      <= phase_next;
      crc        <= crc_next;
      remaining  <= remaining_next;
      first_byte <= first_byte_next;
      spurious   <= spurious_next;
      exc_code   <= exc_code_next;
      crc_low    <= crc_low_next;
    end
  end

  // Form the result beat
  assign emit                    = status_emit | data_emit;
  assign result.result_kind      = status_emit;
  assign result.data_byte        = data_emit ? rx_byte : 8'd0;
  assign result.frame_status     = status_emit ? status : mrc_pkg::ST_OK;
  assign result.spurious_skipped = spurious_next;
  assign result.last_of_frame    = status_emit;

endmodule

// ===== sv/modbus_rtu_response_checker.sv =====
// Top level of the Modbus RTU response checker: input register, core, result register.
//
//   channel | direction | handshake            | payload
//   in      | receive   | in_valid / in_stall   | rx_byte, frame_start
//   out     | send      | out_valid / out_stall | result_kind, data_byte, frame_status,
//           |           |                       | spurious_skipped, last_of_frame
//   cfg     | receive   | cfg_write             | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; it waits in the input register and
// its result is loaded into the result register when that register is free.
// The input register lets a new byte enter while a result still waits downstream.
// in_stall rises only when the input register is full and the result register is
// held by out_stall. Reset is synchronous; it clears the frame state and loads the
// register defaults. No clearing pass follows reset.
module modbus_rtu_response_checker #(
  parameter int unsigned MAX_PAYLOAD = mrc_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  input  logic                            frame_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            result_kind,
  output logic [7:0]                      data_byte,
  output logic [2:0]                      frame_status,
  output logic                            spurious_skipped,
  output logic                            last_of_frame
);

  mrc_pkg::cfg_t    cfg;
  mrc_pkg::result_t result;
  mrc_pkg::result_t out_reg;
  logic             emit;
  logic             in_v;
  logic [7:0]       in_byte;
  logic             in_start;
  logic             out_free;
  logic             advance;

  mrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mrc_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .step        (advance),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .emit        (emit),
    .result      (result)
  );

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_v && out_free;
  assign in_stall = in_v && !advance;

  // Capture an input beat whenever the register is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!in_stall) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte  <= rx_byte;
      in_start <= frame_start;
    end
  end

  // Load the result register when it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_reg <= result;
    end
  end

  assign result_kind      = out_reg.result_kind;
  assign data_byte        = out_reg.data_byte;
  assign frame_status     = out_reg.frame_status;
  assign spurious_skipped = out_reg.spurious_skipped;
  assign last_of_frame    = out_reg.last_of_frame;

endmodule
